// ----- design/srr_pkg.sv -----
`default_nettype none
package srr_pkg;

  localparam int ScreenWidth  = 224;
  localparam int ScreenHeight = 288;
  localparam int GfxBytes     = 8192;
  localparam int LutEntries   = 256;
  localparam int GfxAw        = $clog2(GfxBytes);
  localparam int LutAw        = $clog2(LutEntries);
  localparam int GfxWords     = GfxBytes / 4;
  localparam int GfxWaw       = $clog2(GfxWords);
  localparam int XOffset      = 41;
  localparam int YOffset      = 32;

  typedef enum logic [1:0] {
    CMD_GFX_WR = 2'd0,
    CMD_LUT_WR = 2'd1,
    CMD_DRAW   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_GAME_MODE = 2'd0,
    CFG_FLIP      = 2'd1,
    CFG_PAL_BASE  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // One classified word passed from the front part to the back part.
  typedef struct packed {
    cmd_t              cmd;
    logic [GfxAw-1:0]  addr;
    logic [7:0]        data;
    logic [7:0]        code;
    logic [7:0]        lut_base;
    logic signed [9:0] base_y;
    logic signed [10:0] base_x;
    logic              fx;
    logic              fy;
    logic              szx;
    logic              szy;
  } srr_job_t;

  // Scrambled byte address of the first byte of a graphics row.
  function automatic logic [GfxAw-1:0] gfx_row_addr(input logic [6:0] code,
                                                    input logic [3:0] row);
    logic [12:0] a;
    logic [12:0] b;
    begin
      a = {code, row, 2'b00};
      b = (a & 13'h1f83) | ((a & 13'h003c) << 1) | ((a & 13'h0040) >> 4);
      gfx_row_addr = b[GfxAw-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/srr_front.sv -----
`default_nettype none
module srr_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [12:0]                in_mem_addr,
  input  wire logic [7:0]                 in_mem_data,
  input  wire logic [7:0]                 in_tile_code,
  input  wire logic [7:0]                 in_color_byte,
  input  wire logic [7:0]                 in_y_byte,
  input  wire logic [7:0]                 in_x_low,
  input  wire logic [1:0]                 in_x_high,
  input  wire logic [3:0]                 in_attr_bits,
  input  wire logic                       game_mode,
  input  wire logic                       flip_screen,
  input  wire logic [7:0]                 pal_base,
  output srr_pkg::srr_job_t               q_data,
  output logic                            q_valid,
  input  wire logic                       q_pop
);

  localparam int Depth = 2;

  srr_pkg::srr_job_t mem_r [Depth];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  srr_pkg::srr_job_t job;
  logic [7:0] yv;
  logic push_ok;

  // Classify the incoming word and work out the sprite's position.
  always_comb begin
    job          = '0;
    job.cmd      = srr_pkg::cmd_t'(in_cmd);
    job.addr     = in_mem_addr;
    job.data     = in_mem_data;
    job.code     = in_tile_code;
    job.lut_base = {1'b0, in_color_byte[4:0], 2'b00} + pal_base;
    yv           = 8'd1 - in_y_byte - {in_attr_bits[3], 4'b0000};
    job.base_y   = $signed({2'b00, yv}) - 10'sd32;
    job.base_x   = $signed({1'b0, in_x_high, in_x_low}) - 11'sd41;
    job.fx       = in_attr_bits[0] ^ (game_mode & flip_screen);
    job.fy       = in_attr_bits[1] ^ (game_mode & flip_screen);
    job.szx      = in_attr_bits[2];
    job.szy      = in_attr_bits[3];
  end

  assign in_full = (cnt_r == 2'(Depth));
  assign push_ok = in_push && !in_full && (in_cmd != srr_pkg::CMD_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];

  // Short queue between front and back.
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, q_pop && q_valid};
    end
  end

endmodule
`default_nettype wire

// ----- design/srr_back.sv -----
`default_nettype none
module srr_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srr_pkg::srr_job_t  q_data,
  input  wire logic               q_valid,
  output logic                    q_pop,
  output logic signed [8:0]       out_row_y,
  output logic signed [10:0]      out_row_x_start,
  output logic                    out_step_left,
  output logic [63:0]             out_pixel_colors,
  output logic [15:0]             out_pixel_mask,
  output logic                    out_last,
  output logic                    out_empty,
  input  wire logic               out_pop
);

  typedef enum logic [1:0] {S_IDLE, S_LUT, S_READ, S_EMIT} state_t;

  // Graphics held as four-byte words, one byte per bank, so a row reads in one go.
  logic [7:0] gfx0 [srr_pkg::GfxWords];
  logic [7:0] gfx1 [srr_pkg::GfxWords];
  logic [7:0] gfx2 [srr_pkg::GfxWords];
  logic [7:0] gfx3 [srr_pkg::GfxWords];
  logic [3:0] lut_mem [srr_pkg::LutEntries];

  state_t state_r;
  srr_pkg::srr_job_t job_r;
  logic ty_r, tx_r;
  logic [3:0] r_r;
  logic [1:0] lp_r;
  logic [3:0] lut_c_r [4];
  logic [31:0] gdata_r;
  logic signed [9:0] y_r;
  logic signed [10:0] x0_r;
  logic last_r;

  logic out_full_r;
  logic can_emit;
  logic emit;
  logic [1:0] sel;
  logic [7:0] tcode;
  logic [12:0] raddr;
  logic [srr_pkg::GfxWaw-1:0] wrow;
  logic signed [9:0] ty0, ycur;
  logic signed [10:0] x0;
  logic [63:0] cols;
  logic [15:0] mask;
  logic yin;
  logic signed [11:0] xi;
  logic [1:0] pen;
  logic is_last;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_empty = !out_full_r;
  assign can_emit = !out_full_r || out_pop;
  assign emit = (state_r == S_EMIT) && can_emit;

  // Address, position and last flag of the current tile row.
  always_comb begin
    sel   = {ty_r ^ (job_r.szy & job_r.fy), tx_r ^ (job_r.szx & job_r.fx)};
    tcode = job_r.code + {6'd0, sel};
    raddr = srr_pkg::gfx_row_addr(tcode[6:0], r_r);
    wrow  = raddr[12:2];
    ty0   = job_r.base_y + (ty_r ? 10'sd16 : 10'sd0);
    ycur  = job_r.fy ? (ty0 + 10'sd15 - $signed({6'd0, r_r})) : (ty0 + $signed({6'd0, r_r}));
    x0    = job_r.base_x + (tx_r ? 11'sd16 : 11'sd0) + (job_r.fx ? 11'sd15 : 11'sd0);
    is_last = (ty_r == job_r.szy) && (tx_r == job_r.szx) && (r_r == 4'd15);
  end

  // Pixel decode from the four cached lookup colours, and the on-screen mask.
  always_comb begin
    cols = '0;
    mask = '0;
    yin  = (y_r >= 10'sd0) && (y_r < 10'(srr_pkg::ScreenHeight));
    for (int i = 0; i < 16; i++) begin
      pen = gdata_r[31-2*i -: 2];
      cols[4*i +: 4] = lut_c_r[pen];
      xi = job_r.fx ? ($signed({x0_r[10], x0_r}) - 12'(i))
                    : ($signed({x0_r[10], x0_r}) + 12'(i));
      mask[i] = (lut_c_r[pen] != 4'd0) && yin && (xi >= 12'sd0) &&
                (xi < 12'(srr_pkg::ScreenWidth));
    end
  end

  // Store writes, the lookup colour cache and the graphics word read.
  always_ff @(posedge clk) begin
    if (q_pop && q_data.cmd == srr_pkg::CMD_GFX_WR) begin
      case (q_data.addr[1:0])
        2'd0: gfx0[q_data.addr[12:2]] <= q_data.data;
        2'd1: gfx1[q_data.addr[12:2]] <= q_data.data;
        2'd2: gfx2[q_data.addr[12:2]] <= q_data.data;
        default: gfx3[q_data.addr[12:2]] <= q_data.data;
      endcase
    end
    if (q_pop && q_data.cmd == srr_pkg::CMD_LUT_WR)
      lut_mem[q_data.addr[7:0]] <= q_data.data[3:0];
    if (state_r == S_LUT)
      lut_c_r[lp_r] <= lut_mem[job_r.lut_base | {6'd0, lp_r}];
    if (state_r == S_READ)
      gdata_r <= {gfx0[wrow], gfx1[wrow], gfx2[wrow], gfx3[wrow]};
  end

  // Row sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_full_r <= 1'b0;
      ty_r <= 1'b0;
      tx_r <= 1'b0;
      r_r  <= '0;
      lp_r <= '0;
    end else begin
      if (emit) out_full_r <= 1'b1;
      else if (out_pop && out_full_r) out_full_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            job_r <= q_data;
            ty_r  <= 1'b0;
            tx_r  <= 1'b0;
            r_r   <= '0;
            lp_r  <= '0;
            if (q_data.cmd == srr_pkg::CMD_DRAW) state_r <= S_LUT;
          end
        end
        S_LUT: begin
          lp_r <= lp_r + 2'd1;
          if (lp_r == 2'd3) state_r <= S_READ;
        end
        S_READ: begin
          y_r     <= ycur;
          x0_r    <= x0;
          last_r  <= is_last;
          state_r <= S_EMIT;
          r_r <= r_r + 4'd1;
          if (r_r == 4'd15) begin
            if (tx_r == job_r.szx) begin
              tx_r <= 1'b0;
              ty_r <= ~ty_r;
            end else begin
              tx_r <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_row_y        <= y_r[8:0];
            out_row_x_start  <= x0_r;
            out_step_left    <= job_r.fx;
            out_pixel_colors <= cols;
            out_pixel_mask   <= mask;
            out_last         <= last_r;
            state_r          <= last_r ? S_IDLE : S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/sprite_row_renderer_core.sv -----
`default_nettype none
// Channel | Direction | Handshake         | Content
// in_     | input     | in_push / in_full | one command word per push
// out_    | output    | out_empty/out_pop | one tile row per pop
// cfg_    | input     | cfg_valid/ready   | register index and data
// A draw holds the back part for a pop, a load of its four lookup colours,
// then per tile row a graphics word read and a decode into the output
// register; a sprite has 16 to 64 rows. Store writes take effect in the
// back part as their word is popped. Reset is synchronous and clears only
// control state; the stores stay undefined until written.
// A full output register stalls the row sequencer; the two-entry queue
// in front keeps accepting words meanwhile until it holds two.
module sprite_row_renderer_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [12:0]       in_mem_addr,
  input  wire logic [7:0]        in_mem_data,
  input  wire logic [7:0]        in_tile_code,
  input  wire logic [7:0]        in_color_byte,
  input  wire logic [7:0]        in_y_byte,
  input  wire logic [7:0]        in_x_low,
  input  wire logic [1:0]        in_x_high,
  input  wire logic [3:0]        in_attr_bits,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic signed [8:0]      out_row_y,
  output logic signed [10:0]     out_row_x_start,
  output logic                   out_step_left,
  output logic [63:0]            out_pixel_colors,
  output logic [15:0]            out_pixel_mask,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  logic game_mode_r, flip_r;
  logic [7:0] pal_base_r;
  srr_pkg::srr_job_t q_data;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      game_mode_r <= 1'b0;
      flip_r      <= 1'b0;
      pal_base_r  <= '0;
    end else if (cfg_valid) begin
      case (srr_pkg::cfg_idx_t'(cfg_index))
        srr_pkg::CFG_GAME_MODE: game_mode_r <= cfg_data[0];
        srr_pkg::CFG_FLIP:      flip_r      <= cfg_data[0];
        srr_pkg::CFG_PAL_BASE:  pal_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  srr_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_cmd, .in_mem_addr, .in_mem_data,
    .in_tile_code, .in_color_byte, .in_y_byte, .in_x_low, .in_x_high,
    .in_attr_bits,
    .game_mode(game_mode_r), .flip_screen(flip_r), .pal_base(pal_base_r),
    .q_data, .q_valid, .q_pop
  );

  srr_back u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop,
    .out_row_y, .out_row_x_start, .out_step_left, .out_pixel_colors,
    .out_pixel_mask, .out_last, .out_empty, .out_pop
  );

`ifndef SYNTH
  // The queue is never popped while it holds nothing.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  // A waiting word that is not popped keeps its colours on the result port.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_pixel_colors)))
    else $error("result changed while stalled");
  // A masked pixel 0 always carries a non-zero colour.
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pixel_mask[0]) |-> (out_pixel_colors[3:0] != 4'd0))
    else $error("mask set on a transparent pixel");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_sprite_row_renderer_core.sv -----
`default_nettype none
module tb_sprite_row_renderer_core;
  import srr_pkg::*;

  // One expected tile row word.
  typedef struct {
    logic [8:0]  row_y;
    logic [10:0] x_start;
    logic        step_left;
    logic [63:0] colors;
    logic [15:0] mask;
    logic        last;
  } tile_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [12:0] in_mem_addr;
  logic [7:0]  in_mem_data;
  logic [7:0]  in_tile_code;
  logic [7:0]  in_color_byte;
  logic [7:0]  in_y_byte;
  logic [7:0]  in_x_low;
  logic [1:0]  in_x_high;
  logic [3:0]  in_attr_bits;
  logic        out_empty;
  logic        out_pop;
  logic signed [8:0]  out_row_y;
  logic signed [10:0] out_row_x_start;
  logic        out_step_left;
  logic [63:0] out_pixel_colors;
  logic [15:0] out_pixel_mask;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Shadow copies of the stores and the registers.
  logic [7:0] gfx_shadow [GfxBytes];
  logic [7:0] lut_shadow [LutEntries];
  logic       mode_shadow;
  logic       flip_shadow;
  logic [7:0] pal_base_shadow;

  tile_row_t  pending_rows[$];
  int         error_count;
  bit         quiet;

  sprite_row_renderer_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [12:0] row_byte_addr(input logic [6:0] code, input logic [3:0] row);
    logic [12:0] a;
    a = {code, row, 2'b00};
    return {a[12:7], a[5:2], a[6], a[1:0]};
  endfunction

  // Only tiles 0x7e, 0x7f, 0x00 and 0x01 hold graphics; every tile of the
  // sprite must fall among them.
  function automatic logic [7:0] pick_code(input logic [3:0] attr);
    logic [6:0] low;
    case ($urandom_range(0, 2))
      0: low = 7'h7f;
      1: low = 7'h00;
      default: low = 7'h7e;
    endcase
    if (low == 7'h7f && attr[3] && attr[2]) low = 7'h7e;
    if (low == 7'h00 && attr[3]) low = 7'h7e;
    return {1'($urandom), low};
  endfunction

  // Colour groups 0 and 31 are the ones whose lookup entries get loaded.
  function automatic logic [7:0] pick_color();
    return {3'($urandom), ($urandom_range(0, 1) == 0) ? 5'h00 : 5'h1f};
  endfunction

  // One of the sixteen lookup entries that draws can reach.
  function automatic logic [7:0] lut_slot(input logic [3:0] k);
    return {k[3], {5{k[2]}}, k[1:0]};
  endfunction

  // Works out every tile row that one accepted word gives rise to.
  task automatic predict_word(input cmd_t c, input logic [12:0] addr, input logic [7:0] data,
                              input logic [7:0] code, input logic [7:0] color,
                              input logic [7:0] yb, input logic [7:0] xl,
                              input logic [1:0] xh, input logic [3:0] attr);
    int         bx, by, ty0, x0, y, x;
    logic       fx, fy, szx, szy, yin;
    logic [7:0] lut_base, tcode, lidx;
    logic [1:0] sel;
    logic [12:0] a;
    logic [31:0] bits;
    logic [3:0] col;
    tile_row_t  r;
    case (c)
      CMD_GFX_WR: gfx_shadow[addr] = data;
      CMD_LUT_WR: lut_shadow[addr[7:0]] = data;
      CMD_DRAW: begin
        fx = attr[0];
        fy = attr[1];
        szx = attr[2];
        szy = attr[3];
        bx = int'(xl) - XOffset + 256 * int'(xh);
        by = int'(8'(9'd257 - yb - (szy ? 8'd16 : 8'd0))) - YOffset;
        lut_base = {color[4:0], 2'b00} + pal_base_shadow;
        if (mode_shadow && flip_shadow) begin
          fx = ~fx;
          fy = ~fy;
        end
        for (int ty = 0; ty <= szy; ty++) begin
          for (int tx = 0; tx <= szx; tx++) begin
            sel = {1'(ty) ^ (szy & fy), 1'(tx) ^ (szx & fx)};
            tcode = code + 8'(sel);
            ty0 = by + 16 * ty;
            x0 = bx + 16 * tx + (fx ? 15 : 0);
            for (int rw = 0; rw < 16; rw++) begin
              y = fy ? ty0 + 15 - rw : ty0 + rw;
              yin = (y >= 0) && (y < ScreenHeight);
              a = row_byte_addr(tcode[6:0], 4'(rw));
              bits = {gfx_shadow[a], gfx_shadow[a + 13'd1], gfx_shadow[a + 13'd2],
                      gfx_shadow[a + 13'd3]};
              r.colors = '0;
              r.mask = '0;
              for (int i = 0; i < 16; i++) begin
                lidx = lut_base | 8'(bits[30 - 2 * i +: 2]);
                col = lut_shadow[lidx][3:0];
                x = fx ? x0 - i : x0 + i;
                r.colors[4 * i +: 4] = col;
                if (col != 0 && yin && x >= 0 && x < ScreenWidth) r.mask[i] = 1'b1;
              end
              r.row_y = 9'(y);
              r.x_start = 11'(x0);
              r.step_left = fx;
              r.last = (ty == szy) && (tx == szx) && (rw == 15);
              pending_rows.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sends one word and predicts its rows once it is accepted.
  task automatic send_word(input cmd_t c, input logic [12:0] addr, input logic [7:0] data,
                           input logic [7:0] code, input logic [7:0] color,
                           input logic [7:0] yb, input logic [7:0] xl,
                           input logic [1:0] xh, input logic [3:0] attr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= c;
    in_mem_addr <= addr;
    in_mem_data <= data;
    in_tile_code <= code;
    in_color_byte <= color;
    in_y_byte <= yb;
    in_x_low <= xl;
    in_x_high <= xh;
    in_attr_bits <= attr;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_word(c, addr, data, code, color, yb, xl, xh, attr);
  endtask

  task automatic send_draw(input logic [7:0] code, input logic [7:0] color,
                           input logic [7:0] yb, input logic [7:0] xl,
                           input logic [1:0] xh, input logic [3:0] attr);
    send_word(CMD_DRAW, 13'($urandom), 8'($urandom), code, color, yb, xl, xh, attr);
  endtask

  task automatic send_store(input cmd_t c, input logic [12:0] addr, input logic [7:0] data);
    send_word(c, addr, data, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              2'($urandom), 4'($urandom));
  endtask

  // Waits until every expected row has come, then lets the back part settle.
  task automatic drain();
    in_push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GAME_MODE: mode_shadow = value[0];
      CFG_FLIP:      flip_shadow = value[0];
      CFG_PAL_BASE:  pal_base_shadow = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic mode, input logic flip, input logic [7:0] base);
    drain();
    write_reg(CFG_GAME_MODE, {7'($urandom), mode});
    write_reg(CFG_FLIP, {7'($urandom), flip});
    write_reg(CFG_PAL_BASE, base);
  endtask

  // Fills the reachable lookup entries and the four tiles that draws use,
  // so that no draw ever reads an unwritten entry.
  task automatic test_load_stores();
    quiet = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_store(CMD_LUT_WR, {5'($urandom), lut_slot(4'(i))},
                 ($urandom_range(0, 3) == 0) ? {4'($urandom), 4'h0} : 8'($urandom));
    end
    quiet = 1'b0;
    for (int i = 0; i < 256; i++) begin
      if (i % 64 == 0) quiet = ~quiet;
      send_store(CMD_GFX_WR, (i < 128) ? 13'(i) : 13'h1f00 + 13'(i), 8'($urandom));
    end
    quiet = 1'b0;
  endtask

  // Every size and flip, position extremes, code wrap and the unused command.
  task automatic test_directed_draws();
    for (int a = 0; a < 16; a++) begin
      send_draw(pick_code(4'(a)), pick_color(), 8'(a * 16), 8'(a * 13), 2'(a), 4'(a));
    end
    send_draw(8'hfe, 8'hff, 8'hff, 8'hff, 2'd3, 4'hf);
    send_draw(8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 4'h0);
    send_draw(8'h7e, 8'h1f, 8'h01, 8'd41, 2'd0, 4'hc);
    send_draw(8'hfe, 8'he0, 8'hf1, 8'd40, 2'd1, 4'h5);
    send_word(CMD_NONE, 13'h1fff, 8'hff, 8'h12, 8'h34, 8'h56, 8'h78, 2'd2, 4'h9);
    send_store(CMD_LUT_WR, 13'h1f00, 8'h0f);
    send_draw(8'h80, 8'h00, 8'h80, 8'h80, 2'd0, 4'h3);
    drain();
  endtask

  task automatic test_random(input int count);
    int pick;
    logic [3:0] attr;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        attr = ($urandom_range(0, 2) == 0) ? 4'($urandom) : {2'b00, 2'($urandom)};
        send_draw(pick_code(attr), pick_color(), 8'($urandom), 8'($urandom), 2'($urandom),
                  attr);
      end else if (pick < 78) begin
        send_store(CMD_GFX_WR, 13'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        send_store(CMD_LUT_WR, {5'($urandom), lut_slot(4'($urandom))}, 8'($urandom));
      end else begin
        send_word(CMD_NONE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 2'($urandom), 4'($urandom));
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  // Result side: random pop stalls with quiet stretches.
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  // Compares each popped word with the oldest expected row.
  always @(posedge clk) begin
    tile_row_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_rows.size() == 0) begin
        report("row with nothing expected");
      end else begin
        e = pending_rows.pop_front();
        if (out_row_y !== e.row_y)
          report($sformatf("row_y %h exp %h", out_row_y, e.row_y));
        if (out_row_x_start !== e.x_start)
          report($sformatf("row_x_start %h exp %h", out_row_x_start, e.x_start));
        if (out_step_left !== e.step_left)
          report($sformatf("step_left %b exp %b", out_step_left, e.step_left));
        if (out_pixel_colors !== e.colors)
          report($sformatf("pixel_colors %h exp %h", out_pixel_colors, e.colors));
        if (out_pixel_mask !== e.mask)
          report($sformatf("pixel_mask %h exp %h", out_pixel_mask, e.mask));
        if (out_last !== e.last)
          report($sformatf("last %b exp %b", out_last, e.last));
      end
    end
  end

  initial begin
    error_count = 0;
    quiet = 1'b0;
    mode_shadow = 1'b0;
    flip_shadow = 1'b0;
    pal_base_shadow = 8'd0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_cmd = CMD_NONE;
    in_mem_addr = '0;
    in_mem_data = '0;
    in_tile_code = '0;
    in_color_byte = '0;
    in_y_byte = '0;
    in_x_low = '0;
    in_x_high = '0;
    in_attr_bits = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAME_MODE;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_stores();
    set_regs(1'b0, 1'b0, 8'd0);
    test_directed_draws();
    set_regs(1'b1, 1'b1, 8'd128);
    test_directed_draws();
    set_regs(1'b0, 1'b1, 8'd128);
    test_random(6);
    set_regs(1'b1, 1'b1, 8'd0);
    test_random(6);
    set_regs(1'b1, 1'b0, 8'd128);
    test_random(6);
    set_regs(1'b1, 1'b1, 8'd1);
    test_random(6);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
